// ===== hw/rtl/phr_pkg.sv =====
// phr_pkg: shared types and constants for the primary hue recolor block.
// Depends on nothing; imported by every module under hw/rtl.
package phr_pkg;

	localparam int PIX_W      = 24;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFF_FFFF;
	localparam logic [PIX_W-1:0] PIX_BLACK = 24'h00_0000;
	localparam logic [2*CH_W-1:0] BLUE_ROUND = 16'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_TARGET   = 3'd0,
		REG_GREEN_TARGET = 3'd1,
		REG_BLUE_TARGET  = 3'd2,
		REG_CH_ENABLES   = 3'd3,
		REG_KEY_COLOR    = 3'd4,
		REG_KEY_ENABLE   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_target;
		logic [PIX_W-1:0] green_target;
		logic [PIX_W-1:0] blue_target;
		logic [2:0]       ch_enables;
		logic [PIX_W-1:0] key_color;
		logic             key_enable;
	} phr_cfg_t;

endpackage

// ===== hw/rtl/phr_cfg_regs.sv =====
// phr_cfg_regs: configuration register file written through the cfg channel.
// Depends on phr_pkg for the register index codes and the phr_cfg_t bundle.
module phr_cfg_regs import phr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output phr_cfg_t              cfg
);

	phr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RED_TARGET:   cfg_q.red_target   <= cfg_data[PIX_W-1:0];
				REG_GREEN_TARGET: cfg_q.green_target <= cfg_data[PIX_W-1:0];
				REG_BLUE_TARGET:  cfg_q.blue_target  <= cfg_data[PIX_W-1:0];
				REG_CH_ENABLES:   cfg_q.ch_enables   <= cfg_data[2:0];
				REG_KEY_COLOR:    cfg_q.key_color    <= cfg_data[PIX_W-1:0];
				REG_KEY_ENABLE:   cfg_q.key_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/phr_recolor_core.sv =====
// phr_recolor_core: input register, key/shade classification, scaling and result register.
// Depends on phr_pkg for widths, constants and the phr_cfg_t bundle.
module phr_recolor_core import phr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  phr_cfg_t         cfg,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] in_pixel,
	output logic             res_valid,
	output logic             res_write_enable,
	output logic [PIX_W-1:0] res_pixel
);

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             valid_s2;
	logic             we_s2;
	logic [PIX_W-1:0] pixel_s2;

	logic             keyed;
	logic             is_red, is_green, is_blue, remap;
	logic [CH_W-1:0]  level;
	logic [PIX_W-1:0] target;
	logic [2*CH_W-1:0] prod_r, prod_g, prod_b;
	logic [PIX_W-1:0] scaled;
	logic [PIX_W-1:0] next_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			pixel_s1 <= in_pixel;
		end
		if (valid_s1) begin
			we_s2    <= !keyed;
			pixel_s2 <= next_pixel;
		end
	end

	always_comb begin
		keyed    = cfg.key_enable && (pixel_s1 == cfg.key_color);
		is_red   = (pixel_s1[15:0] == '0);
		is_green = !is_red && (pixel_s1[23:16] == '0) && (pixel_s1[7:0] == '0);
		is_blue  = !is_red && !is_green && (pixel_s1[23:8] == '0);
		level    = pixel_s1[7:0];
		target   = cfg.blue_target;
		remap    = is_blue && cfg.ch_enables[2];
		if (is_red) begin
			level  = pixel_s1[23:16];
			target = cfg.red_target;
			remap  = cfg.ch_enables[0];
		end else if (is_green) begin
			level  = pixel_s1[15:8];
			target = cfg.green_target;
			remap  = cfg.ch_enables[1];
		end
		prod_r = target[23:16] * level;
		prod_g = target[15:8] * level;
		prod_b = target[7:0] * level + BLUE_ROUND;
		scaled = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};
		if (keyed) begin
			next_pixel = PIX_BLACK;
		end else if (pixel_s1 == PIX_WHITE || pixel_s1 == PIX_BLACK || !remap) begin
			next_pixel = pixel_s1;
		end else begin
			next_pixel = scaled;
		end
	end

	assign res_valid        = valid_s2;
	assign res_write_enable = we_s2;
	assign res_pixel        = pixel_s2;

	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2) else $error("result strobe lost");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !valid_s2) else $error("result strobe without transaction");
	a_keyed_black: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !we_s2 |-> pixel_s2 == PIX_BLACK) else $error("keyed pixel not zero");
	a_keyed_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !we_s2 |-> $past(cfg.key_enable)) else $error("keyed with keying off");

endmodule

// ===== hw/rtl/primary_hue_recolor.sv =====
// primary_hue_recolor: top level, recolors pure red/green/blue shades and applies color keying.
// Depends on phr_pkg, phr_cfg_regs and phr_recolor_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------
//   input    | start, busy           | src_pixel
//   result   | result_valid (strobe) | write_enable, out_pixel
//   config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// One pixel per clock while busy is low; each result passes through the input register
// and then the result register, which sit around three 8x8 multipliers.
// busy is high during reset and is cleared by its register on the clock edge after reset is released, then stays low.
// cfg_ready is always high; a register write is accepted whenever cfg_valid is high.
// The receiver cannot stall: a result is on the ports for exactly one cycle.
module primary_hue_recolor import phr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [PIX_W-1:0]      src_pixel,
	output logic                  result_valid,
	output logic                  write_enable,
	output logic [PIX_W-1:0]      out_pixel,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	phr_cfg_t cfg;
	logic     busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	phr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	phr_recolor_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.in_valid         (start && !busy_q),
		.in_pixel         (src_pixel),
		.res_valid        (result_valid),
		.res_write_enable (write_enable),
		.res_pixel        (out_pixel)
	);

endmodule

// ===== tb/tb_primary_hue_recolor.sv =====
`timescale 1ns / 1ps
// tb_primary_hue_recolor: self-checking testbench for the primary hue recolor block.
// Compares every pixel result against a local recolor/keying predictor; uses phr_pkg.
// Needs primary_hue_recolor and its submodules, nothing else.
module tb_primary_hue_recolor;
	import phr_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned MAX_GAP      = 18;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned RAND_PHASES  = 8;
	localparam int unsigned PHASE_PIXELS = 80;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic             wr;
		logic [PIX_W-1:0] pix;
	} pixel_result_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic [PIX_W-1:0]      src_pixel    = '0;
	logic                  cfg_valid    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  busy;
	logic                  result_valid;
	logic                  write_enable;
	logic [PIX_W-1:0]      out_pixel;
	logic                  cfg_ready;

	// local copy of the register file
	logic [PIX_W-1:0] red_tgt  = '0;
	logic [PIX_W-1:0] grn_tgt  = '0;
	logic [PIX_W-1:0] blu_tgt  = '0;
	logic [2:0]       ch_ena   = '0;
	logic [PIX_W-1:0] key_rgb  = '0;
	logic             key_on   = 1'b0;

	logic [PIX_W-1:0] pixel_feed[$];
	pixel_result_t    pending_results[$];
	int unsigned      idle_pct    = 0;
	int unsigned      gap_left    = 0;
	int unsigned      err_count   = 0;
	int unsigned      cycle_count = 0;

	primary_hue_recolor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.src_pixel    (src_pixel),
		.result_valid (result_valid),
		.write_enable (write_enable),
		.out_pixel    (out_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [PIX_W-1:0] scale_shade(logic [PIX_W-1:0] tgt, logic [7:0] lvl);
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		r = {8'd0, tgt[23:16]} * {8'd0, lvl};
		g = {8'd0, tgt[15:8]} * {8'd0, lvl};
		b = {8'd0, tgt[7:0]} * {8'd0, lvl} + BLUE_ROUND;
		return {r[15:8], g[15:8], b[15:8]};
	endfunction

	function automatic pixel_result_t recolor_pixel(logic [PIX_W-1:0] px);
		pixel_result_t    res;
		logic             hit;
		logic [PIX_W-1:0] tgt;
		logic [7:0]       lvl;
		res.wr  = 1'b1;
		res.pix = px;
		hit     = 1'b0;
		tgt     = '0;
		lvl     = '0;
		if (key_on && px == key_rgb) begin
			res.wr  = 1'b0;
			res.pix = '0;
			return res;
		end
		if (px == PIX_WHITE || px == PIX_BLACK)
			return res;
		if (px[15:0] == 16'd0) begin
			hit = ch_ena[0];
			tgt = red_tgt;
			lvl = px[23:16];
		end else if (px[23:16] == 8'd0 && px[7:0] == 8'd0) begin
			hit = ch_ena[1];
			tgt = grn_tgt;
			lvl = px[15:8];
		end else if (px[23:8] == 16'd0) begin
			hit = ch_ena[2];
			tgt = blu_tgt;
			lvl = px[7:0];
		end
		if (hit)
			res.pix = scale_shade(tgt, lvl);
		return res;
	endfunction

	function automatic int unsigned draw_gap();
		if ($urandom_range(99) < idle_pct)
			return $urandom_range(0, MAX_GAP);
		return 0;
	endfunction

	function automatic logic [PIX_W-1:0] pick_color();
		case ($urandom_range(0, 5))
			0: return PIX_BLACK;
			1: return PIX_WHITE;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pure_shade();
		logic [7:0] lvl;
		case ($urandom_range(0, 3))
			0: lvl = 8'd1;
			1: lvl = 8'd255;
			default: lvl = 8'($urandom_range(1, 255));
		endcase
		return PIX_W'(lvl) << (16 - 8 * $urandom_range(0, 2));
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return pure_shade();
		if (pick < 50)
			return ($urandom_range(1)) ? PIX_WHITE : PIX_BLACK;
		if (pick < 62)
			return key_rgb;
		return PIX_W'($urandom);
	endfunction

	// driver: one transaction per start & !busy, gaps drawn per pixel
	always @(posedge clk) begin : drv
		logic fire;
		fire = start && !busy;
		if (arst_n) begin
			if (fire)
				pending_results.push_back(recolor_pixel(src_pixel));
			if (fire || !start) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pixel_feed.size() > 0) begin
					start     <= 1'b1;
					src_pixel <= pixel_feed.pop_front();
					gap_left  = draw_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results cannot be held off, check each strobe
	always @(posedge clk) begin : mon
		pixel_result_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: we=%0b pix=%06h", write_enable, out_pixel);
			end else begin
				want = pending_results.pop_front();
				if (write_enable !== want.wr || out_pixel !== want.pix) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: expected we=%0b pix=%06h, got we=%0b pix=%06h",
							want.wr, want.pix, write_enable, out_pixel);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** primary_hue_recolor: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RED_TARGET:   red_tgt = val;
			REG_GREEN_TARGET: grn_tgt = val;
			REG_BLUE_TARGET:  blu_tgt = val;
			REG_CH_ENABLES:   ch_ena  = val[2:0];
			REG_KEY_COLOR:    key_rgb = val;
			REG_KEY_ENABLE:   key_on  = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pixel_feed.size() != 0 || pending_results.size() != 0 || start)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_setup();
		write_reg(REG_RED_TARGET, pick_color());
		write_reg(REG_GREEN_TARGET, pick_color());
		write_reg(REG_BLUE_TARGET, pick_color());
		write_reg(REG_CH_ENABLES, CFG_DATA_W'($urandom));
		write_reg(REG_KEY_COLOR, pick_color());
		write_reg(REG_KEY_ENABLE, CFG_DATA_W'($urandom));
		if ($urandom_range(1))
			write_reg(($urandom_range(1)) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: nothing remapped, no keying
		idle_pct = 0;
		pixel_feed.push_back(24'hFF_0000);
		pixel_feed.push_back(24'h00_8000);
		pixel_feed.push_back(24'h00_0001);
		pixel_feed.push_back(PIX_BLACK);
		wait_drained();

		// all channels on: full, zero and odd targets
		write_reg(REG_RED_TARGET, PIX_WHITE);
		write_reg(REG_GREEN_TARGET, PIX_BLACK);
		write_reg(REG_BLUE_TARGET, 24'h12_3456);
		write_reg(REG_CH_ENABLES, 24'hFF_FFFF);
		idle_pct = 50;
		pixel_feed.push_back(24'h01_0000);
		pixel_feed.push_back(24'hFF_0000);
		pixel_feed.push_back(24'h80_0000);
		pixel_feed.push_back(24'h00_FF00);
		pixel_feed.push_back(24'h00_0100);
		pixel_feed.push_back(24'h00_00FF);
		pixel_feed.push_back(24'h00_0001);
		pixel_feed.push_back(PIX_BLACK);
		pixel_feed.push_back(PIX_WHITE);
		pixel_feed.push_back(24'hFF_00FF);
		pixel_feed.push_back(24'h00_FFFF);
		pixel_feed.push_back(24'hFF_FF00);
		pixel_feed.push_back(24'h12_3456);
		pixel_feed.push_back(24'h7F_7F7F);
		wait_drained();

		// keying on pure red, green remap off, ignored register slots
		write_reg(REG_KEY_COLOR, 24'hFF_0000);
		write_reg(REG_KEY_ENABLE, 24'h00_0001);
		write_reg(REG_CH_ENABLES, 24'h00_0005);
		write_reg(REG_SPARE_6, PIX_WHITE);
		write_reg(REG_SPARE_7, 24'h5A_A55A);
		idle_pct = 100;
		pixel_feed.push_back(24'hFF_0000);
		pixel_feed.push_back(24'h7F_0000);
		pixel_feed.push_back(24'h00_4000);
		pixel_feed.push_back(24'h00_00FF);
		pixel_feed.push_back(PIX_WHITE);
		pixel_feed.push_back(PIX_BLACK);
		wait_drained();

		for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
			random_setup();
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 100;
				default: idle_pct = 30;
			endcase
			for (int unsigned n = 0; n < PHASE_PIXELS; n++)
				pixel_feed.push_back(random_pixel());
			wait_drained();
		end

		if (pending_results.size() != 0) begin
			err_count++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		if (err_count == 0)
			$display("** primary_hue_recolor: PASSED **");
		else
			$display("** primary_hue_recolor: FAILED **");
		$finish;
	end

endmodule
